FILE: sv/tcsd_pkg.sv
package tcsd_pkg;

   // Input item as seen on the request channel
   typedef struct packed {
      logic               operation;
      logic [3:0]         target_chain;
      logic signed [31:0] log_probability;
      logic [15:0]        pick_fraction;
      logic [15:0]        accept_fraction;
   } req_type;

   // Result item as seen on the response channel
   typedef struct packed {
      logic        swap_done;
      logic        accepted;
      logic [3:0]  lower_chain;
      logic [3:0]  cold_chain;
      logic [31:0] attempt_total;
      logic [31:0] accept_total;
   } rsp_type;

   // Operation codes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_SWAP  = 1'b1;

   // Configuration register indexes
   localparam int  CSR_INDEX_W      = 1;
   localparam int  CSR_DATA_W       = 24;
   localparam logic CSR_CHAIN_COUNT = 1'b0;
   localparam logic CSR_HEAT_STEP   = 1'b1;

   localparam logic [4:0]  CHAIN_COUNT_RESET = 5'd4;
   localparam logic [23:0] HEAT_STEP_RESET   = 24'd13107;

   // Classified command kinds passed from front to back
   localparam logic [1:0] KIND_WRITE = 2'd0;
   localparam logic [1:0] KIND_SKIP  = 2'd1;
   localparam logic [1:0] KIND_SWAP  = 2'd2;

   typedef struct packed {
      logic [1:0]         kind;
      logic [4:0]         slot;
      logic signed [31:0] value;
      logic [15:0]        accept_fraction;
   } cmd_type;

   // Shared divider request and response
   localparam int DIV_NUM_W = 34;
   localparam int DIV_DEN_W = 30;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] dividend;
      logic [DIV_DEN_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_NUM_W-1:0] quotient;
   } div_rsp_type;

   // Exponential approximation constants
   localparam logic [30:0] LOG2E_Q30    = 31'd1549082005;
   localparam logic [31:0] LN2_Q32      = 32'd2977044472;
   localparam int          EXP_TERMS    = 12;
   localparam logic [48:0] REJECT_LIMIT = 49'd100 << 32;

endpackage

FILE: sv/tcsd_queue.sv
module tcsd_queue
   import tcsd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_data,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_data
);

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push_go, pop_go;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push_go    = push_valid && push_ready;
   assign pop_go     = pop_valid && pop_ready;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push_go ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop_go ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push_go && !pop_go) begin
         count_in = count_ff + 2'd1;
      end else if (pop_go && !push_go) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store item
   always_ff @(posedge clock) begin
      if (push_go) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: sv/tcsd_front.sv
module tcsd_front
   import tcsd_pkg::*;
#(
   parameter int MAX_CHAINS = 16
)
(
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   input  logic [4:0] chain_count,
   output logic       push_valid,
   input  logic       push_ready,
   output cmd_type    push_data
);

   logic [4:0]  eff_count;
   logic [4:0]  span;
   logic [20:0] pick_prod;

   // Saturate the chain count to the storage depth
   always_comb begin
      if (int'(chain_count) > MAX_CHAINS) begin
         eff_count = 5'(MAX_CHAINS);
      end else begin
         eff_count = chain_count;
      end
   end

   assign span      = eff_count - 5'd1;
   assign pick_prod = 21'(req_data.pick_fraction) * 21'(span);

   // Classify item
   always_comb begin
      push_data.value           = req_data.log_probability;
      push_data.accept_fraction = req_data.accept_fraction;
      if (req_data.operation == OP_WRITE) begin
         push_data.slot = {1'b0, req_data.target_chain};
         if (5'(req_data.target_chain) < eff_count) begin
            push_data.kind = KIND_WRITE;
         end else begin
            push_data.kind = KIND_SKIP;
         end
      end else begin
         push_data.slot = pick_prod[20:16];
         if (eff_count >= 5'd2) begin
            push_data.kind = KIND_SWAP;
         end else begin
            push_data.kind = KIND_SKIP;
         end
      end
   end

   assign push_valid = req_valid;
   assign req_ready  = push_ready;

endmodule

FILE: sv/tcsd_div.sv
module tcsd_div
   import tcsd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   localparam int CNT_W = $clog2(DIV_NUM_W + 1);

   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_DEN_W:0]   trial;

   assign trial = {rem_ff, quo_ff[DIV_NUM_W-1]};

   // One quotient bit per cycle, restoring
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         quo_in  = div_req.dividend;
         rem_in  = '0;
         den_in  = div_req.divisor;
         cnt_in  = CNT_W'(DIV_NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DIV_DEN_W'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[DIV_NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIV_DEN_W-1:0];
            quo_in = {quo_ff[DIV_NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

FILE: sv/tcsd_back.sv
module tcsd_back
   import tcsd_pkg::*;
#(
   parameter int MAX_CHAINS = 16
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   output logic        cmd_ready,
   input  cmd_type     cmd_data,
   input  logic [23:0] heat_step,
   output div_req_type div_req,
   input  div_rsp_type div_rsp,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data
);

   localparam int IDX_W = $clog2(MAX_CHAINS);

   localparam logic [4:0] S_IDLE    = 5'd0;
   localparam logic [4:0] S_READ    = 5'd1;
   localparam logic [4:0] S_DIV_J   = 5'd2;
   localparam logic [4:0] S_WAIT_J  = 5'd3;
   localparam logic [4:0] S_DIV_K   = 5'd4;
   localparam logic [4:0] S_WAIT_K  = 5'd5;
   localparam logic [4:0] S_LNR_MUL = 5'd6;
   localparam logic [4:0] S_LNR     = 5'd7;
   localparam logic [4:0] S_Y       = 5'd8;
   localparam logic [4:0] S_YR      = 5'd9;
   localparam logic [4:0] S_ZR      = 5'd10;
   localparam logic [4:0] S_TMUL    = 5'd11;
   localparam logic [4:0] S_TDIV    = 5'd12;
   localparam logic [4:0] S_TWAIT   = 5'd13;
   localparam logic [4:0] S_FINAL   = 5'd14;
   localparam logic [4:0] S_RESULT  = 5'd15;
   localparam logic [4:0] S_SWAP_K  = 5'd16;

   // Chain stores
   logic signed [31:0] lp_mem   [MAX_CHAINS];
   logic [IDX_W-1:0]   rank_mem [MAX_CHAINS];
   logic [MAX_CHAINS-1:0] lp_vld_ff, rank_vld_ff;

   logic signed [31:0] lp_j_rd, lp_k_rd;
   logic [IDX_W-1:0]   rank_j_rd, rank_k_rd;
   logic               lp_vj_rd, lp_vk_rd, rank_vj_rd, rank_vk_rd;

   logic [4:0]        state_ff, state_in;
   logic [1:0]        kind_ff, kind_in;
   logic [IDX_W-1:0]  j_ff, j_in;
   logic [IDX_W-1:0]  k_idx;
   logic [15:0]       u_ff, u_in;
   logic              acc_ff, acc_in;
   logic              diff_neg_ff, diff_neg_in;
   logic [32:0]       diff_mag_ff, diff_mag_in;
   logic [16:0]       bj_ff, bj_in, bk_ff, bk_in;
   logic              bd_neg_ff, bd_neg_in;
   logic [16:0]       bd_mag_ff, bd_mag_in;
   logic [22:0]       x16_ff, x16_in;
   logic [7:0]        n_ff, n_in;
   logic [31:0]       z_ff, z_in;
   logic [32:0]       t_ff, t_in;
   logic [33:0]       s_ff, s_in;
   logic [3:0]        term_ff, term_in;
   logic [IDX_W-1:0]  cold_ff, cold_in;
   logic [31:0]       attempt_ff, attempt_in, accept_ff, accept_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic [31:0]        mul_a, mul_b;
   logic [63:0]        prod_ff;
   logic signed [31:0] lp_j, lp_k;
   logic [IDX_W-1:0]   rank_j, rank_k, rank_sel;
   logic signed [32:0] diff;
   logic [29:0]        heat_den;
   logic signed [17:0] bd;
   logic [48:0]        lnr_mag;
   logic               lnr_neg;
   logic [31:0]        term_p;
   logic [33:0]        exp_val;
   logic               out_free, swap_acc;
   logic               lp_we, rank_we;
   logic [IDX_W-1:0]   lp_waddr, rank_waddr, rank_wdata;
   logic               rd_en;
   logic [IDX_W-1:0]   rd_j, rd_k;

   assign k_idx  = IDX_W'(j_ff + IDX_W'(1));
   assign lp_j   = lp_vj_rd ? lp_j_rd : 32'sd0;
   assign lp_k   = lp_vk_rd ? lp_k_rd : 32'sd0;
   assign rank_j = rank_vj_rd ? rank_j_rd : j_ff;
   assign rank_k = rank_vk_rd ? rank_k_rd : k_idx;
   assign diff   = 33'(lp_k) - 33'(lp_j);
   assign bd     = $signed({1'b0, bj_ff}) - $signed({1'b0, bk_ff});
   assign lnr_mag  = diff_mag_ff[32] ? {bd_mag_ff, 32'd0} : prod_ff[48:0];
   assign lnr_neg  = (bd_neg_ff ^ diff_neg_ff) && (lnr_mag != 49'd0);
   assign term_p   = t_ff[32] ? z_ff : prod_ff[63:32];
   assign exp_val  = (n_ff >= 8'd64) ? 34'd0 : (s_ff >> n_ff);
   assign rank_sel = (state_ff == S_DIV_J) ? rank_j : rank_k;
   assign heat_den = 30'h10000 + 30'(heat_step) * 30'(rank_sel);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign swap_acc = (kind_ff == KIND_SWAP) && acc_ff;
   assign rd_j     = IDX_W'(cmd_data.slot);
   assign rd_k     = IDX_W'(rd_j + IDX_W'(1));

   assign cmd_ready = (state_ff == S_IDLE);
   assign rd_en     = cmd_ready && cmd_valid;

   // Shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_LNR_MUL: begin
            mul_a = 32'(bd_mag_in);
            mul_b = diff_mag_ff[31:0];
         end
         S_Y: begin
            mul_a = 32'(x16_ff);
            mul_b = 32'(LOG2E_Q30);
         end
         S_YR: begin
            mul_a = prod_ff[45:14];
            mul_b = LN2_Q32;
         end
         S_TMUL: begin
            mul_a = t_ff[31:0];
            mul_b = z_ff;
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= 64'(mul_a) * 64'(mul_b);
   end

   // Divider requests
   always_comb begin
      div_req.start    = 1'b0;
      div_req.dividend = '0;
      div_req.divisor  = '0;
      case (state_ff)
         S_DIV_J, S_DIV_K: begin
            div_req.start    = 1'b1;
            div_req.dividend = 34'h1_0000_0000 + 34'(heat_den >> 1);
            div_req.divisor  = heat_den;
         end
         S_TDIV: begin
            div_req.start    = 1'b1;
            div_req.dividend = 34'(term_p);
            div_req.divisor  = 30'(term_ff);
         end
         default: begin
            div_req.start = 1'b0;
         end
      endcase
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      j_in         = j_ff;
      u_in         = u_ff;
      acc_in       = acc_ff;
      diff_neg_in  = diff_neg_ff;
      diff_mag_in  = diff_mag_ff;
      bj_in        = bj_ff;
      bk_in        = bk_ff;
      bd_neg_in    = bd_neg_ff;
      bd_mag_in    = bd_mag_ff;
      x16_in       = x16_ff;
      n_in         = n_ff;
      z_in         = z_ff;
      t_in         = t_ff;
      s_in         = s_ff;
      term_in      = term_ff;
      cold_in      = cold_ff;
      attempt_in   = attempt_ff;
      accept_in    = accept_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      lp_we        = 1'b0;
      lp_waddr     = rd_j;
      rank_we      = 1'b0;
      rank_waddr   = j_ff;
      rank_wdata   = rank_k;
      case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               kind_in = cmd_data.kind;
               j_in    = rd_j;
               u_in    = cmd_data.accept_fraction;
               acc_in  = 1'b0;
               if (cmd_data.kind == KIND_WRITE) begin
                  lp_we    = 1'b1;
                  state_in = S_RESULT;
               end else if (cmd_data.kind == KIND_SWAP) begin
                  state_in = S_READ;
               end else begin
                  state_in = S_RESULT;
               end
            end
         end
         S_READ: begin
            diff_neg_in = diff[32];
            diff_mag_in = diff[32] ? 33'(-diff) : 33'(diff);
            state_in    = S_DIV_J;
         end
         S_DIV_J: state_in = S_WAIT_J;
         S_WAIT_J: begin
            if (div_rsp.done) begin
               bj_in    = div_rsp.quotient[16:0];
               state_in = S_DIV_K;
            end
         end
         S_DIV_K: state_in = S_WAIT_K;
         S_WAIT_K: begin
            if (div_rsp.done) begin
               bk_in    = div_rsp.quotient[16:0];
               state_in = S_LNR_MUL;
            end
         end
         S_LNR_MUL: begin
            bd_neg_in = bd[17];
            bd_mag_in = bd[17] ? 17'(-bd) : 17'(bd);
            state_in  = S_LNR;
         end
         S_LNR: begin
            if (!lnr_neg) begin
               acc_in   = 1'b1;
               state_in = S_RESULT;
            end else if (lnr_mag > REJECT_LIMIT) begin
               acc_in   = 1'b0;
               state_in = S_RESULT;
            end else begin
               x16_in   = lnr_mag[38:16];
               state_in = S_Y;
            end
         end
         S_Y: state_in = S_YR;
         S_YR: begin
            n_in     = prod_ff[53:46];
            state_in = S_ZR;
         end
         S_ZR: begin
            z_in     = prod_ff[63:32];
            t_in     = 33'h1_0000_0000;
            s_in     = 34'h1_0000_0000;
            term_in  = 4'd1;
            state_in = S_TMUL;
         end
         S_TMUL: state_in = S_TDIV;
         S_TDIV: state_in = S_TWAIT;
         S_TWAIT: begin
            if (div_rsp.done) begin
               t_in = div_rsp.quotient[32:0];
               if (term_ff[0]) begin
                  s_in = s_ff - 34'(div_rsp.quotient[32:0]);
               end else begin
                  s_in = s_ff + 34'(div_rsp.quotient[32:0]);
               end
               term_in = term_ff + 4'd1;
               if (term_ff == 4'(EXP_TERMS - 1)) begin
                  state_in = S_FINAL;
               end else begin
                  state_in = S_TMUL;
               end
            end
         end
         S_FINAL: begin
            acc_in   = (34'({u_ff, 16'd0}) < exp_val);
            state_in = S_RESULT;
         end
         S_RESULT: begin
            if (out_free) begin
               if (kind_ff == KIND_SWAP) begin
                  attempt_in = attempt_ff + 32'd1;
               end
               if (swap_acc) begin
                  accept_in = accept_ff + 32'd1;
                  if (cold_ff == j_ff) begin
                     cold_in = k_idx;
                  end else if (cold_ff == k_idx) begin
                     cold_in = j_ff;
                  end
                  rank_we  = 1'b1;
                  state_in = S_SWAP_K;
               end else begin
                  state_in = S_IDLE;
               end
               rsp_valid_in              = 1'b1;
               rsp_data_in.swap_done     = (kind_ff == KIND_SWAP);
               rsp_data_in.accepted      = swap_acc;
               rsp_data_in.lower_chain   = (kind_ff == KIND_SWAP) ? 4'(j_ff) : 4'd0;
               rsp_data_in.cold_chain    = 4'(cold_in);
               rsp_data_in.attempt_total = attempt_in;
               rsp_data_in.accept_total  = accept_in;
            end
         end
         S_SWAP_K: begin
            rank_we    = 1'b1;
            rank_waddr = k_idx;
            rank_wdata = rank_j;
            state_in   = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cold_ff      <= '0;
         attempt_ff   <= '0;
         accept_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         lp_vld_ff    <= '0;
         rank_vld_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         cold_ff      <= cold_in;
         attempt_ff   <= attempt_in;
         accept_ff    <= accept_in;
         rsp_valid_ff <= rsp_valid_in;
         if (lp_we) begin
            lp_vld_ff[lp_waddr] <= 1'b1;
         end
         if (rank_we) begin
            rank_vld_ff[rank_waddr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      j_ff        <= j_in;
      u_ff        <= u_in;
      acc_ff      <= acc_in;
      diff_neg_ff <= diff_neg_in;
      diff_mag_ff <= diff_mag_in;
      bj_ff       <= bj_in;
      bk_ff       <= bk_in;
      bd_neg_ff   <= bd_neg_in;
      bd_mag_ff   <= bd_mag_in;
      x16_ff      <= x16_in;
      n_ff        <= n_in;
      z_ff        <= z_in;
      t_ff        <= t_in;
      s_ff        <= s_in;
      term_ff     <= term_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Memory writes and registered pair reads
   always_ff @(posedge clock) begin
      if (lp_we) begin
         lp_mem[lp_waddr] <= cmd_data.value;
      end
      if (rank_we) begin
         rank_mem[rank_waddr] <= rank_wdata;
      end
      if (rd_en) begin
         lp_j_rd    <= lp_mem[rd_j];
         lp_k_rd    <= lp_mem[rd_k];
         rank_j_rd  <= rank_mem[rd_j];
         rank_k_rd  <= rank_mem[rd_k];
         lp_vj_rd   <= lp_vld_ff[rd_j];
         lp_vk_rd   <= lp_vld_ff[rd_k];
         rank_vj_rd <= rank_vld_ff[rd_j];
         rank_vk_rd <= rank_vld_ff[rd_k];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: sv/tempered_chain_swap_decider.sv
// Neighbor replica-exchange decider for parallel tempering. Write items store a
// chain's Q15.16 log-probability; swap items pick the neighbor pair j, j+1 from
// pick_fraction, derive both heats from their ranks, and accept the exchange by
// the Metropolis rule, swapping heat ranks and tracking the cold chain. Every
// item gives exactly one result. Items pass through a two-entry queue into a
// sequencer. In a swap attempt one bit-serial divider forms both heat
// reciprocals and the eleven series terms of the exponential; attempts
// decided by sign or by the lower bound skip the series. Configuration writes
// take effect at once; the user must make them only while the block is idle,
// as the block itself does not enforce this.
module tempered_chain_swap_decider
   import tcsd_pkg::*;
#(
   parameter int MAX_CHAINS = 16
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   logic [4:0]  chain_count_ff, chain_count_in;
   logic [23:0] heat_step_ff, heat_step_in;

   logic        push_valid, push_ready;
   cmd_type     push_data;
   logic        pop_valid, pop_ready;
   cmd_type     pop_data;
   div_req_type div_req;
   div_rsp_type div_rsp;

   // Configuration registers
   always_comb begin
      chain_count_in = chain_count_ff;
      heat_step_in   = heat_step_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_CHAIN_COUNT: chain_count_in = csr_write_data[4:0];
            CSR_HEAT_STEP:   heat_step_in   = csr_write_data[23:0];
            default:         chain_count_in = chain_count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_count_ff <= CHAIN_COUNT_RESET;
         heat_step_ff   <= HEAT_STEP_RESET;
      end else begin
         chain_count_ff <= chain_count_in;
         heat_step_ff   <= heat_step_in;
      end
   end

   tcsd_front #(.MAX_CHAINS(MAX_CHAINS)) u_front (
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .chain_count (chain_count_ff),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_data   (push_data)
   );

   tcsd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   tcsd_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   tcsd_back #(.MAX_CHAINS(MAX_CHAINS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (pop_valid),
      .cmd_ready (pop_ready),
      .cmd_data  (pop_data),
      .heat_step (heat_step_ff),
      .div_req   (div_req),
      .div_rsp   (div_rsp),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: bench/tb.sv
module tb;
   import tcsd_pkg::*;

   // Swap-decision predictor and store of expected results
   class swap_ledger;
      logic signed [63:0] log_prob [16];
      logic [3:0]         rank [16];
      logic [3:0]         cold;
      logic [31:0]        attempts;
      logic [31:0]        accepts;
      logic [4:0]         count;
      logic [23:0]        step;
      rsp_type            pending [$];
      int                 errors;

      function new();
         for (int i = 0; i < 16; i++) begin
            log_prob[i] = 0;
            rank[i] = 4'(i);
         end
         cold = 0;
         attempts = 0;
         accepts = 0;
         count = CHAIN_COUNT_RESET;
         step = HEAT_STEP_RESET;
         errors = 0;
      endfunction

      function logic [63:0] heat(logic [3:0] r);
         logic [63:0] d;
         d = 64'd65536 + 64'(step) * 64'(r);
         return ((64'd1 << 32) + d / 2) / d;
      endfunction

      // exp(-x) for x in Q.32, result Q0.32
      function logic [63:0] exp_neg(logic [63:0] x);
         logic [63:0] y, n, g, z, t, s;
         y = ((x >> 16) * 64'd1549082005) >> 14;
         n = y >> 32;
         g = y & 64'hFFFF_FFFF;
         z = (g * 64'd2977044472) >> 32;
         t = 64'd1 << 32;
         s = t;
         for (int i = 1; i < 12; i++) begin
            t = ((t * z) >> 32) / i;
            if (i % 2) s = s - t;
            else s = s + t;
         end
         if (n >= 64) return 0;
         return s >> n;
      endfunction

      function void note_item(req_type r);
         rsp_type e;
         logic [4:0] n;
         logic [3:0] j, k, tr;
         logic signed [63:0] bj, bk, diff, lnr;
         logic acc;
         n = (count > 16) ? 5'd16 : count;
         e = '0;
         if (r.operation == OP_WRITE) begin
            if (r.target_chain < n) log_prob[r.target_chain] = r.log_probability;
         end else if (n >= 2) begin
            j = 4'((32'(r.pick_fraction) * 32'(n - 1)) >> 16);
            k = j + 4'd1;
            attempts++;
            bj = heat(rank[j]);
            bk = heat(rank[k]);
            diff = log_prob[k] - log_prob[j];
            if (diff > (64'sd1 <<< 40)) diff = 64'sd1 <<< 40;
            if (diff < -(64'sd1 <<< 40)) diff = -(64'sd1 <<< 40);
            lnr = (bj - bk) * diff;
            if (lnr >= 0) acc = 1;
            else if (lnr < -(64'sd100 <<< 32)) acc = 0;
            else acc = ((64'(r.accept_fraction) << 16) < exp_neg(64'(-lnr)));
            if (acc) begin
               if (cold == j) cold = k;
               else if (cold == k) cold = j;
               tr = rank[j];
               rank[j] = rank[k];
               rank[k] = tr;
               accepts++;
            end
            e.swap_done = 1;
            e.accepted = acc;
            e.lower_chain = j;
         end
         e.cold_chain = cold;
         e.attempt_total = attempts;
         e.accept_total = accepts;
         pending.insert(pending.size(), e);
      endfunction

      function void check_result(rsp_type a);
         rsp_type e;
         if (pending.size() == 0) begin
            $display("%0t unexpected result %h", $time, a);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a.swap_done !== e.swap_done || a.accepted !== e.accepted ||
             a.lower_chain !== e.lower_chain || a.cold_chain !== e.cold_chain ||
             a.attempt_total !== e.attempt_total ||
             a.accept_total !== e.accept_total) begin
            $display("%0t mismatch expected %h actual %h", $time, e, a);
            errors++;
         end
      endfunction
   endclass

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   req_type         req_data;
   logic            rsp_valid;
   logic            rsp_ready;
   rsp_type         rsp_data;
   logic            csr_write_enable;
   logic [0:0]      csr_index;
   logic [23:0]     csr_write_data;

   swap_ledger ledger;
   int  idle_cycles;
   bit  hold_off;

   tempered_chain_swap_decider u_top (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // Count cycles without any handshake
   always @(posedge clock) begin
      if (reset) idle_cycles <= 0;
      else if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   // Check accepted results
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) ledger.check_result(rsp_data);
   end

   // Receiver stall pattern, with one long hold-off on request
   initial begin
      bit held;
      held = 0;
      rsp_ready = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off && !held) begin
            held = 1;
            rsp_ready <= 0;
            repeat (3000) @(posedge clock);
         end
         case ($urandom_range(0, 3))
            0: rsp_ready <= 1;
            1: rsp_ready <= ($urandom_range(0, 9) != 0);
            2: rsp_ready <= $urandom_range(0, 1);
            default: rsp_ready <= ($urandom_range(0, 4) == 0);
         endcase
      end
   end

   task automatic send_item(req_type r);
      req_valid <= 1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      ledger.note_item(r);
   endtask

   task automatic gap();
      int g;
      g = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
      if (g > 0) begin
         req_valid <= 0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 0;
      while (ledger.pending.size() != 0) @(posedge clock);
      repeat (600) @(posedge clock);
   endtask

   task automatic write_csr(logic [0:0] idx, logic [23:0] val);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= val;
      @(posedge clock);
      csr_write_enable <= 0;
      @(posedge clock);
   endtask

   function automatic req_type random_item(int write_pct);
      req_type r;
      r.operation = ($urandom_range(0, 99) < write_pct) ? OP_WRITE : OP_SWAP;
      r.target_chain = 4'($urandom_range(0, 15));
      case ($urandom_range(0, 3))
         0: r.log_probability = $urandom;
         1: r.log_probability = $urandom_range(0, 200000) - 100000;
         2: r.log_probability = $urandom_range(0, 20000000) - 10000000;
         default: r.log_probability = $urandom_range(0, 2000) - 1000;
      endcase
      r.pick_fraction = 16'($urandom);
      r.accept_fraction = 16'($urandom);
      return r;
   endfunction

   function automatic req_type make_item(logic op, logic [3:0] c, logic [31:0] p,
                                         logic [15:0] pf, logic [15:0] af);
      req_type r;
      r.operation = op;
      r.target_chain = c;
      r.log_probability = p;
      r.pick_fraction = pf;
      r.accept_fraction = af;
      return r;
   endfunction

   initial begin
      int burst;
      logic [4:0] counts [6] = '{5'd2, 5'd16, 5'd1, 5'd31, 5'd7, 5'd0};
      logic [23:0] steps [6] = '{24'd0, 24'hFFFFFF, 24'd65536, 24'd13107, 24'd300,
                                 24'd5000};
      ledger = new();
      reset = 1;
      req_valid = 0;
      req_data = '0;
      csr_write_enable = 0;
      csr_index = 0;
      csr_write_data = 0;
      hold_off = 0;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: extremes, small ratio, rejection bound, ignored write
      send_item(make_item(OP_WRITE, 0, 32'h7FFFFFFF, 0, 0));
      send_item(make_item(OP_WRITE, 1, 32'h80000000, 16'hFFFF, 16'hFFFF));
      send_item(make_item(OP_WRITE, 2, 32'd65536, 0, 0));
      send_item(make_item(OP_WRITE, 3, 32'd0, 0, 0));
      send_item(make_item(OP_WRITE, 15, 32'd12345, 0, 0));
      send_item(make_item(OP_SWAP, 0, 0, 16'd0, 16'd0));
      send_item(make_item(OP_SWAP, 0, 0, 16'hFFFF, 16'hFFFF));
      send_item(make_item(OP_SWAP, 0, 0, 16'h8000, 16'd0));
      send_item(make_item(OP_WRITE, 2, 32'hFFFF0000, 0, 0));
      send_item(make_item(OP_SWAP, 0, 0, 16'h8000, 16'd0));
      send_item(make_item(OP_SWAP, 0, 0, 16'h8000, 16'hFFFF));
      send_item(make_item(OP_WRITE, 3, 32'h7FFFFFFF, 0, 0));
      send_item(make_item(OP_SWAP, 0, 0, 16'hFFFF, 16'd0));
      send_item(make_item(OP_SWAP, 0, 0, 16'hFFFF, 16'd0));
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         write_csr(CSR_CHAIN_COUNT, 24'(counts[ph]));
         write_csr(CSR_HEAT_STEP, steps[ph]);
         ledger.count = counts[ph];
         ledger.step = steps[ph];
         if (ph == 1) hold_off = 1;
         for (int i = 0; i < 130; i += burst) begin
            burst = $urandom_range(1, 20);
            for (int b = 0; b < burst; b++)
               send_item(random_item(ph == 1 ? 70 : 50));
            gap();
         end
         drain();
      end

      while (ledger.pending.size() != 0) @(posedge clock);
      repeat (600) @(posedge clock);
      if (ledger.errors == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

   // Watchdog
   always @(posedge clock) begin
      if (idle_cycles > 20000) begin
         $display("status: fail");
         $finish;
      end
   end

endmodule
